### design/bev_pkg.sv
package bev_pkg;

  localparam int FIELD_W = 16;
  localparam int INDEX_W = 4;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_VALUE_MIN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VALUE_MAX    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_DELAY = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DOWN_BUTTON  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UP_BUTTON    = 3'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_UP   = 2'd2;

  localparam logic [FIELD_W-1:0] REPEAT_BACKOFF = 16'd5;

  typedef logic [FIELD_W-1:0] field_t;

endpackage

### design/button_edge_and_value_editor.sv
// Button edge detector with an up/down value editor. One beat in per clock:
// each accepted input beat produces exactly one output beat, registered, in the
// cycle after acceptance. The whole update (edge masks, toggle bits, clamp,
// step and auto-repeat counter) is done combinationally from the input beat and
// the held state, so throughput is one beat per cycle; the single output
// register sets the rate, and s_tready drops only while a result sits in it
// and m_tready is low. Configuration writes are always accepted (cfg_ready
// is tied high) and should be made while the block is idle.
module button_edge_and_value_editor
  import bev_pkg::*;
#(
  parameter int BUTTON_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // buttons_raw, toggle_clear_mask, value_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [79:0]           m_tdata,   // instant_mask, press_mask, release_mask,
                                           // toggle_mask, value_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [FIELD_W-1:0]    cfg_data
);

  localparam field_t BUTTON_MASK = (BUTTON_COUNT >= FIELD_W) ? {FIELD_W{1'b1}} :
                                   FIELD_W'((1 << BUTTON_COUNT) - 1);

  field_t             value_min;
  field_t             value_max;
  field_t             repeat_delay;
  logic [INDEX_W-1:0] down_button;
  logic [INDEX_W-1:0] up_button;

  field_t     previous_buttons;
  field_t     toggle_bits;
  logic [1:0] held_direction;
  field_t     repeat_count;

  field_t     now, clr, value_raw, pressed, released, toggles, clamped;
  field_t     value_next, toggle_bits_next, repeat_count_next, count_inc;
  logic [1:0] held_direction_next;
  logic       down_held, up_held, at_limit, step;
  logic [1:0] dir;
  field_t     limit;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    now       = s_tdata[15:0] & BUTTON_MASK;
    clr       = s_tdata[31:16] & BUTTON_MASK;
    value_raw = s_tdata[47:32];
    pressed   = ~previous_buttons & now;
    released  = ~now & previous_buttons;
    toggles   = toggle_bits ^ pressed;

    clamped = (value_raw < value_min) ? value_min : value_raw;
    clamped = (clamped > value_max) ? value_max : clamped;

    // masked bits read as released, which covers out-of-range indexes
    down_held = now[down_button];
    up_held   = now[up_button];
    dir       = down_held ? DIR_DOWN : DIR_UP;
    limit     = down_held ? value_min : value_max;
    at_limit  = clamped == limit;
    count_inc = repeat_count + 16'd1;

    held_direction_next = held_direction;
    repeat_count_next   = repeat_count;
    step                = 1'b0;
    if (!down_held && !up_held) begin
      held_direction_next = DIR_NONE;
      repeat_count_next   = '0;
    end else if (!at_limit) begin
      if (held_direction != dir) begin
        held_direction_next = dir;
        step                = 1'b1;
      end else if (count_inc >= repeat_delay) begin
        repeat_count_next = repeat_delay - REPEAT_BACKOFF;
        step              = 1'b1;
      end else begin
        repeat_count_next = count_inc;
      end
    end

    value_next = clamped;
    if (step) begin
      value_next = down_held ? clamped - 16'd1 : clamped + 16'd1;
    end

    toggle_bits_next = toggles & ~clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_min    <= '0;
      value_max    <= 16'hFFFF;
      repeat_delay <= 16'd50;
      down_button  <= 4'd0;
      up_button    <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_VALUE_MIN:    value_min    <= cfg_data;
        REG_VALUE_MAX:    value_max    <= cfg_data;
        REG_REPEAT_DELAY: repeat_delay <= cfg_data;
        REG_DOWN_BUTTON:  down_button  <= cfg_data[INDEX_W-1:0];
        REG_UP_BUTTON:    up_button    <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_buttons <= '0;
      toggle_bits      <= '0;
      held_direction   <= DIR_NONE;
      repeat_count     <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (accept) begin
        previous_buttons <= now;
        toggle_bits      <= toggle_bits_next;
        held_direction   <= held_direction_next;
        repeat_count     <= repeat_count_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {value_next, toggles, released, pressed, now};
    end
  end

endmodule

### design/bev_checker.sv
module bev_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // empty output stage never blocks input
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  // accepted beat shows up on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted beat produced no result");

  // press and release edges agree with the instant levels
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[31:16] & ~m_tdata[15:0]) == '0) &&
                 ((m_tdata[47:32] & m_tdata[15:0]) == '0))
    else $error("edge masks inconsistent with button levels");

  // released bits were held down in the previous result's instant levels
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready ##1 m_tvalid |->
      (m_tdata[47:32] & ~$past(m_tdata[15:0])) == '0)
    else $error("release without prior press");

endmodule

bind button_edge_and_value_editor bev_checker u_bev_checker (.*);
